// File: src/lprd_pkg.sv
// Shared types and constants of the length-prefixed request deframer.
`default_nettype none
package lprd_pkg;

   typedef enum logic [2:0] {
      PH_LEN     = 3'd0,
      PH_COUNT   = 3'd1,
      PH_STRLEN  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CLOSED  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_LEN_BIG  = 3'd1,
      ERR_CNT_BIG  = 3'd2,
      ERR_OVERRUN  = 3'd3,
      ERR_TRAILING = 3'd4,
      ERR_CLOSED   = 3'd5
   } err_type;

   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
   localparam int unsigned FIELD_BYTES   = 4;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  payload_byte;
      logic [15:0] string_index;
      logic        field_done;
      logic [31:0] field_value;
      logic        string_end;
      logic        message_end;
      err_type     error_code;
   } result_type;

endpackage
`default_nettype wire

// File: src/lprd_parser.sv
// Parse state and per-beat decode of the deframer.
`default_nettype none
module lprd_parser #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               new_connection,
   input  wire logic [15:0]        max_len,
   output lprd_pkg::result_type    result
);
   import lprd_pkg::*;

   localparam int MsgW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
   localparam logic [63:0] LenMaskW = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam logic [31:0] LenMask = LenMaskW[31:0];

   phase_type        phase_ff, phase_in;
   logic [1:0]       pos_ff, pos_in;
   logic [23:0]      acc_ff, acc_in;
   logic [MsgW-1:0]  msg_left_ff, msg_left_in;
   logic [15:0]      strings_ff, strings_in;
   logic [MsgW-1:0]  str_left_ff, str_left_in;
   logic [15:0]      idx_ff, idx_in;

   phase_type        ph;
   logic [1:0]       pos;
   logic [23:0]      acc;
   logic [MsgW-1:0]  ml, ml_dec, stl_dec;
   logic [15:0]      sl, idx;
   logic [MsgW-1:0]  stl;
   logic [31:0]      value;
   logic             complete;
   logic             do_after;
   logic [15:0]      after_sl;
   logic [MsgW-1:0]  after_ml;
   logic             close;

   always_comb begin
      if (new_connection) begin
         ph  = PH_LEN;
         pos = '0;
         acc = '0;
         ml  = '0;
         sl  = '0;
         stl = '0;
         idx = '0;
      end else begin
         ph  = phase_ff;
         pos = pos_ff;
         acc = acc_ff;
         ml  = msg_left_ff;
         sl  = strings_ff;
         stl = str_left_ff;
         idx = idx_ff;
      end

      ml_dec   = (ml != '0) ? ml - MsgW'(1) : ml;
      stl_dec  = (stl != '0) ? stl - MsgW'(1) : stl;
      value    = {data_byte, acc};
      complete = 1'b0;
      do_after = 1'b0;
      after_sl = sl;
      after_ml = ml;
      close    = 1'b0;

      phase_in    = ph;
      pos_in      = pos;
      acc_in      = acc;
      msg_left_in = ml;
      strings_in  = sl;
      str_left_in = stl;
      idx_in      = idx;

      result              = '0;
      result.byte_role    = 3'(ph);
      result.error_code   = ERR_NONE;

      case (ph)
         PH_CLOSED: begin
            result.error_code = ERR_CLOSED;
         end
         PH_PAYLOAD: begin
            result.payload_byte = data_byte;
            result.string_index = idx;
            msg_left_in         = ml_dec;
            str_left_in         = stl_dec;
            if (stl_dec == '0) begin
               result.string_end = 1'b1;
               strings_in        = sl - 16'd1;
               idx_in            = idx + 16'd1;
               do_after          = 1'b1;
               after_sl          = sl - 16'd1;
               after_ml          = ml_dec;
            end
         end
         default: begin
            if (ph != PH_LEN) msg_left_in = ml_dec;
            if (ph == PH_STRLEN) result.string_index = idx;
            pos_in   = pos + 2'd1;
            complete = (pos == 2'd3);
            case (pos)
               2'd0:    acc_in[7:0]   = data_byte;
               2'd1:    acc_in[15:8]  = data_byte;
               2'd2:    acc_in[23:16] = data_byte;
               default: acc_in        = '0;
            endcase
         end
      endcase

      if (complete) begin
         result.field_done  = 1'b1;
         result.field_value = value;
         case (ph)
            PH_LEN: begin
               if (value > {16'd0, max_len} || (value & ~LenMask) != 32'd0) begin
                  result.error_code = ERR_LEN_BIG;
               end else if (value < 32'(FIELD_BYTES)) begin
                  result.error_code = ERR_OVERRUN;
               end else begin
                  msg_left_in = value[MsgW-1:0];
                  phase_in    = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (value > {16'd0, max_len}) begin
                  result.error_code = ERR_CNT_BIG;
               end else begin
                  strings_in = value[15:0];
                  idx_in     = '0;
                  do_after   = 1'b1;
                  after_sl   = value[15:0];
                  after_ml   = ml_dec;
               end
            end
            default: begin
               if (value > 32'(ml_dec)) begin
                  result.error_code = ERR_OVERRUN;
               end else if (value == 32'd0) begin
                  result.string_end = 1'b1;
                  strings_in        = sl - 16'd1;
                  idx_in            = idx + 16'd1;
                  do_after          = 1'b1;
                  after_sl          = sl - 16'd1;
                  after_ml          = ml_dec;
               end else begin
                  str_left_in = value[MsgW-1:0];
                  phase_in    = PH_PAYLOAD;
               end
            end
         endcase
      end

      if (do_after) begin
         if (after_sl == 16'd0) begin
            if (after_ml != '0) begin
               result.error_code = ERR_TRAILING;
            end else begin
               result.message_end = 1'b1;
               phase_in    = PH_LEN;
               pos_in      = '0;
               acc_in      = '0;
               msg_left_in = '0;
               strings_in  = '0;
               str_left_in = '0;
               idx_in      = '0;
            end
         end else if (after_ml < MsgW'(FIELD_BYTES)) begin
            result.error_code = ERR_OVERRUN;
         end else begin
            phase_in = PH_STRLEN;
         end
      end

      close = (result.error_code != ERR_NONE) && (result.error_code != ERR_CLOSED);
      if (close) begin
         result.message_end = 1'b0;
         phase_in    = PH_CLOSED;
         pos_in      = '0;
         acc_in      = '0;
         msg_left_in = '0;
         strings_in  = '0;
         str_left_in = '0;
         idx_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         pos_ff      <= '0;
         acc_ff      <= '0;
         msg_left_ff <= '0;
         strings_ff  <= '0;
         str_left_ff <= '0;
         idx_ff      <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         msg_left_ff <= msg_left_in;
         strings_ff  <= strings_in;
         str_left_ff <= str_left_in;
         idx_ff      <= idx_in;
      end
   end

endmodule
`default_nettype wire

// File: src/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer: stream ports and result register.
//
// Input channel req_*: one received byte per beat in req_tdata, req_tuser set on
// the first byte of a new connection (parse state restarts before that byte).
// Result channel rsp_*: exactly one result beat per input beat, in order.
// rsp_tuser carries the byte role, rsp_tlast marks the byte that ends a correct
// message, rsp_tdata the remaining fields.
// A result is valid in the cycle after its beat is accepted. Throughput is one byte per
// clock when not stalled, set by the single parse stage feeding the result register.
// csr_wr_en/csr_wr_data set the maximum message length and string count; write
// only while the block is idle.
// Reset (synchronous) empties the result register, restores the maximum to 4096
// and returns the parser to waiting for a length header.
// When the receiver stalls, the result holds and req_tready drops in the same
// cycle; no beat is lost.
`default_nettype none
module length_prefixed_request_deframer #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] new_connection
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [7:0] payload_byte, [23:8] string_index,
                                         // [24] field_done, [56:25] field_value,
                                         // [57] string_end, [60:58] error_code, pad
   output      logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output      logic        rsp_tlast,   // message_end
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import lprd_pkg::*;

   logic        step;
   logic [15:0] max_len_ff;
   logic        valid_ff;
   result_type  result;
   result_type  rsp_ff;

   assign req_tready = !valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   lprd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .data_byte      (req_tdata),
      .new_connection (req_tuser),
      .max_len        (max_len_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = rsp_ff.byte_role;
   assign rsp_tlast  = rsp_ff.message_end;
   assign rsp_tdata  = {3'b000, 3'(rsp_ff.error_code), rsp_ff.string_end,
                        rsp_ff.field_value, rsp_ff.field_done,
                        rsp_ff.string_index, rsp_ff.payload_byte};

endmodule
`default_nettype wire
